// File: sv/lkv_pkg.sv
// shared types and constants for the lru key-value store
package lkv_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int CAP_W = 5;
  localparam int DATA_W = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
  localparam logic signed [DATA_W-1:0] MISS_VALUE = -32'sd1;

  // request codes
  localparam logic [1:0] FN_LOOKUP = 2'd0;
  localparam logic [1:0] FN_INSERT = 2'd1;
  localparam logic [1:0] FN_ERASE = 2'd2;

  typedef struct packed {
    logic [1:0] func;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] value;
  } lkv_in_t;

  typedef struct packed {
    logic found;
    logic signed [DATA_W-1:0] read_value;
  } lkv_out_t;

  // one stored entry, also what moves between neighbor cells
  typedef struct packed {
    logic valid;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] value;
  } lkv_entry_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic cmp;      // capture key match
    logic promote;  // move hit entry to the front
    logic ins;      // push a new entry at the front
    logic erase;    // remove hit entry, close gap
  } lkv_ctl_t;

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } lkv_state_t;

endpackage

// File: sv/lru_cache_key_value.sv
// top level of the lru key-value store: request control and the cell chain
//
//  channel   | ports                          | handshake
//  ----------+--------------------------------+--------------------------------
//  request   | start, busy, in_data           | word taken when start & !busy
//  result    | out_valid, out_data            | one-cycle strobe, no back-pressure
//  config    | cfg_valid, cfg_ready, cfg_data | write when cfg_valid & cfg_ready
//
// every request passes two states: the idle state registers the key match in
// every cell, the update state moves entries between neighbors; busy is high
// in the update state, so no new word is taken until the last one is applied
// the result word shows on out_data in the cycle after the move, with out_valid high for one cycle
// reset (rst_n low, synchronous) empties the store and sets capacity to 16
// the receiver cannot stall; the result register frees the request side
module lru_cache_key_value
  import lkv_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               start,
  output logic               busy,
  input  lkv_in_t            in_data,
  // result channel
  output logic               out_valid,
  output lkv_out_t           out_data,
  // capacity register write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CAP_W-1:0]   cfg_data
);

  lkv_state_t state_r, state_nxt;

  logic [CAP_W-1:0] cap_r;
  logic [CAP_W-1:0] cap_eff;

  // held request word
  logic [1:0]        func_r;
  logic [DATA_W-1:0] key_r;
  logic [DATA_W-1:0] value_r;

  logic     out_valid_r, out_valid_nxt;
  lkv_out_t out_data_r, out_data_nxt;

  logic     accept;
  lkv_ctl_t ctl;
  logic     found;

  lkv_entry_t hit_entry;
  lkv_entry_t head_in;
  lkv_entry_t new_entry;

  // chain wiring between neighbor cells
  lkv_entry_t cell_entry [DEPTH];
  lkv_entry_t left_in    [DEPTH];
  lkv_entry_t right_in   [DEPTH];
  lkv_entry_t acc_in     [DEPTH];
  lkv_entry_t acc_out    [DEPTH];
  logic       lo_in      [DEPTH];
  logic       lo_out     [DEPTH];
  logic       hi_in      [DEPTH];
  logic       hi_out     [DEPTH];

  assign accept    = start && (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;

  // capacity zero behaves as one; values above DEPTH keep every slot anyway
  assign cap_eff = (cap_r == '0) ? CAP_W'(1) : cap_r;

  // the match at most one slot holds, gathered down the chain to slot 0
  assign hit_entry = acc_out[0];
  assign found     = hit_entry.valid;

  assign new_entry = '{valid: 1'b1, key: key_r, value: value_r};
  // slot 0 takes either the new entry or the promoted one
  assign head_in   = ctl.ins ? new_entry : hit_entry;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (start) state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // cell commands and result word
  always_comb begin
    ctl           = '0;
    busy          = 1'b0;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      ST_IDLE: begin
        ctl.cmp = start;
      end
      ST_UPDATE: begin
        busy          = 1'b1;
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{found: 1'b0, read_value: '0};
        unique case (func_r)
          FN_LOOKUP: begin
            ctl.promote  = found;
            out_data_nxt = '{found: found,
                             read_value: found ? $signed(hit_entry.value) : MISS_VALUE};
          end
          FN_INSERT: begin
            ctl.promote        = found;
            ctl.ins            = !found;
            out_data_nxt.found = found;
          end
          FN_ERASE: begin
            ctl.erase          = found;
            out_data_nxt.found = found;
          end
          default: begin
            // unused code: store untouched, zero result
            out_data_nxt = '{found: 1'b0, read_value: '0};
          end
        endcase
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
    end
    out_data_r <= out_data_nxt;
    if (accept) begin
      func_r  <= in_data.func;
      key_r   <= in_data.key;
      value_r <= in_data.value;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // row of slots, slot 0 most recent
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign left_in[i] = head_in;
      assign lo_in[i]   = 1'b0;
    end else begin : g_body
      assign left_in[i] = cell_entry[i-1];
      assign lo_in[i]   = lo_out[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_in[i] = '0;
      assign hi_in[i]    = 1'b0;
      assign acc_in[i]   = '0;
    end else begin : g_mid
      assign right_in[i] = cell_entry[i+1];
      assign hi_in[i]    = hi_out[i+1];
      assign acc_in[i]   = acc_out[i+1];
    end

    lkv_cell #(
      .IDX (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .req_key  (in_data.key),
      .cap_eff  (cap_eff),
      .left_in  (left_in[i]),
      .right_in (right_in[i]),
      .lo_in    (lo_in[i]),
      .lo_out   (lo_out[i]),
      .hi_in    (hi_in[i]),
      .hi_out   (hi_out[i]),
      .acc_in   (acc_in[i]),
      .acc_out  (acc_out[i]),
      .entry    (cell_entry[i])
    );
  end

endmodule

// File: sv/lkv_cell.sv
// one slot of the recency-ordered chain: entry, key match and neighbor moves
module lkv_cell
  import lkv_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lkv_ctl_t            ctl,
  input  logic [DATA_W-1:0]   req_key,
  input  logic [CAP_W-1:0]    cap_eff,
  input  lkv_entry_t          left_in,
  input  lkv_entry_t          right_in,
  input  logic                lo_in,
  output logic                lo_out,
  input  logic                hi_in,
  output logic                hi_out,
  input  lkv_entry_t          acc_in,
  output lkv_entry_t          acc_out,
  output lkv_entry_t          entry
);

  logic valid_r, valid_nxt;
  logic [DATA_W-1:0] key_r, key_nxt;
  logic [DATA_W-1:0] value_r, value_nxt;
  logic hit_r, hit_nxt;
  logic keep;

  assign entry = '{valid: valid_r, key: key_r, value: value_r};

  // hit at this slot or nearer the front / farther back
  assign lo_out = lo_in | hit_r;
  assign hi_out = hi_in | hit_r;
  // the one hit entry collects toward the front
  assign acc_out = hit_r ? (acc_in | entry) : acc_in;

  assign keep = int'(cap_eff) > IDX;

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    value_nxt = value_r;
    hit_nxt   = hit_r;
    if (ctl.cmp) begin
      hit_nxt = valid_r && (key_r == req_key);
    end
    if (ctl.promote && hi_out) begin
      valid_nxt = left_in.valid;
      key_nxt   = left_in.key;
      value_nxt = left_in.value;
    end else if (ctl.ins) begin
      valid_nxt = left_in.valid & keep;
      key_nxt   = left_in.key;
      value_nxt = left_in.value;
    end else if (ctl.erase && lo_out) begin
      valid_nxt = right_in.valid;
      key_nxt   = right_in.key;
      value_nxt = right_in.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      hit_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      hit_r   <= hit_nxt;
    end
    key_r   <= key_nxt;
    value_r <= value_nxt;
  end

endmodule

// File: bench/lru_cache_key_value_tb.sv
// self-checking testbench for the lru key-value store: directed table, random phases
`timescale 1ns / 100ps

module lru_cache_key_value_tb;
  import lkv_pkg::*;

  localparam int SLOTS = DEPTH_DEF;
  localparam int CYCLE_LIMIT = 500000;
  localparam int WORDS_PER_PHASE = 140;
  localparam int N_PHASES = 10;
  localparam int N_ROWS = 25;

  // the fourth request code does nothing and answers zero
  localparam logic [1:0] FN_NOP = 2'd3;

  typedef enum logic {
    ROW_REQ,
    ROW_CFG
  } row_kind_t;

  // one directed step: a request word or a capacity write
  typedef struct packed {
    row_kind_t kind;
    logic [1:0] func;
    logic [31:0] key;
    logic [31:0] value;
    logic [CAP_W-1:0] cap;
    logic typed;          // expected word written out below
    logic found;
    logic [31:0] rv;
  } dir_row_t;

  localparam dir_row_t DIR_TAB [N_ROWS] = '{
    // empty store: miss, then erase of a missing key
    {ROW_REQ, FN_LOOKUP, 32'h0000_0000, 32'h0000_0000, 5'd0, 1'b1, 1'b0, 32'hFFFF_FFFF},
    {ROW_REQ, FN_ERASE,  32'h0000_0000, 32'h0000_0000, 5'd0, 1'b1, 1'b0, 32'h0000_0000},
    // extreme keys and values
    {ROW_REQ, FN_INSERT, 32'h8000_0000, 32'h7FFF_FFFF, 5'd0, 1'b1, 1'b0, 32'h0000_0000},
    {ROW_REQ, FN_LOOKUP, 32'h8000_0000, 32'h0000_0000, 5'd0, 1'b1, 1'b1, 32'h7FFF_FFFF},
    {ROW_REQ, FN_INSERT, 32'h7FFF_FFFF, 32'h8000_0000, 5'd0, 1'b1, 1'b0, 32'h0000_0000},
    // insert of a present key keeps the old value
    {ROW_REQ, FN_INSERT, 32'h7FFF_FFFF, 32'h0000_0000, 5'd0, 1'b1, 1'b1, 32'h0000_0000},
    {ROW_REQ, FN_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000, 5'd0, 1'b1, 1'b1, 32'h8000_0000},
    // unused code: no effect, zero answer
    {ROW_REQ, FN_NOP,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd0, 1'b1, 1'b0, 32'h0000_0000},
    // stored value equal to the miss answer, told apart by found
    {ROW_REQ, FN_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd0, 1'b1, 1'b0, 32'h0000_0000},
    {ROW_REQ, FN_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 5'd0, 1'b1, 1'b1, 32'hFFFF_FFFF},
    {ROW_REQ, FN_ERASE,  32'h8000_0000, 32'h0000_0000, 5'd0, 1'b1, 1'b1, 32'h0000_0000},
    {ROW_REQ, FN_LOOKUP, 32'h8000_0000, 32'h0000_0000, 5'd0, 1'b1, 1'b0, 32'hFFFF_FFFF},
    {ROW_REQ, FN_ERASE,  32'h8000_0000, 32'h0000_0000, 5'd0, 1'b1, 1'b0, 32'h0000_0000},
    {ROW_REQ, FN_INSERT, 32'h0000_0000, 32'h0000_0000, 5'd0, 1'b1, 1'b0, 32'h0000_0000},
    {ROW_REQ, FN_LOOKUP, 32'h0000_0000, 32'h0000_0000, 5'd0, 1'b1, 1'b1, 32'h0000_0000},
    // capacity lowered below the fill: old entries linger until a new insert
    {ROW_CFG, FN_LOOKUP, 32'h0000_0000, 32'h0000_0000, 5'd1, 1'b0, 1'b0, 32'h0000_0000},
    {ROW_REQ, FN_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 5'd0, 1'b0, 1'b0, 32'h0000_0000},
    {ROW_REQ, FN_INSERT, 32'h0000_0005, 32'hA5A5_A5A5, 5'd0, 1'b0, 1'b0, 32'h0000_0000},
    {ROW_REQ, FN_LOOKUP, 32'h0000_0000, 32'h0000_0000, 5'd0, 1'b0, 1'b0, 32'h0000_0000},
    // capacity zero acts as one
    {ROW_CFG, FN_LOOKUP, 32'h0000_0000, 32'h0000_0000, 5'd0, 1'b0, 1'b0, 32'h0000_0000},
    {ROW_REQ, FN_INSERT, 32'h0000_0006, 32'h0000_0001, 5'd0, 1'b0, 1'b0, 32'h0000_0000},
    {ROW_REQ, FN_INSERT, 32'h0000_0007, 32'h0000_0002, 5'd0, 1'b0, 1'b0, 32'h0000_0000},
    {ROW_REQ, FN_LOOKUP, 32'h0000_0006, 32'h0000_0000, 5'd0, 1'b0, 1'b0, 32'h0000_0000},
    {ROW_REQ, FN_LOOKUP, 32'h0000_0007, 32'h0000_0000, 5'd0, 1'b0, 1'b0, 32'h0000_0000},
    // capacity above the slot count acts as the slot count
    {ROW_CFG, FN_LOOKUP, 32'h0000_0000, 32'h0000_0000, 5'd31, 1'b0, 1'b0, 32'h0000_0000}
  };

  // capacity per random phase: full size first so that the drop to 3 hits a full store
  localparam logic [CAP_W-1:0] PHASE_CAP [N_PHASES] = '{
    5'd16, 5'd3, 5'd1, 5'd31, 5'd0, 5'd9, 5'd2, 5'd16, 5'd5, 5'd12
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  lkv_in_t in_data = '0;
  logic out_valid;
  lkv_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CAP_W-1:0] cfg_data = '0;

  // predicted contents of the store, slot 0 most recent
  logic [31:0] st_key [SLOTS];
  logic [31:0] st_val [SLOTS];
  logic st_vld [SLOTS];
  logic [CAP_W-1:0] cap_reg;

  lkv_out_t expected_words [$];
  int err_cnt = 0;
  int cyc_cnt = 0;
  bit burst_mode = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  lru_cache_key_value u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // move slot h to the front, everything younger ages by one
  function automatic void move_front(int h);
    logic [31:0] k;
    logic [31:0] v;
    k = st_key[h];
    v = st_val[h];
    for (int i = h; i > 0; i--) begin
      st_key[i] = st_key[i-1];
      st_val[i] = st_val[i-1];
      st_vld[i] = st_vld[i-1];
    end
    st_key[0] = k;
    st_val[0] = v;
    st_vld[0] = 1'b1;
  endfunction

  // apply one request word to the predicted store and return its answer
  function automatic lkv_out_t lru_apply(lkv_in_t w);
    lkv_out_t r;
    int hit;
    int lim;
    r = '0;
    hit = -1;
    lim = (cap_reg == 0) ? 1 : ((cap_reg > SLOTS) ? SLOTS : int'(cap_reg));
    if (w.func == FN_NOP) return r;
    for (int i = 0; i < SLOTS; i++)
      if (hit < 0 && st_vld[i] && st_key[i] == w.key) hit = i;
    r.found = (hit >= 0);
    case (w.func)
      FN_LOOKUP: begin
        if (hit >= 0) begin
          r.read_value = st_val[hit];
          move_front(hit);
        end else begin
          r.read_value = MISS_VALUE;
        end
      end
      FN_INSERT: begin
        if (hit >= 0) begin
          move_front(hit);
        end else begin
          for (int i = SLOTS - 1; i > 0; i--) begin
            st_key[i] = st_key[i-1];
            st_val[i] = st_val[i-1];
            st_vld[i] = st_vld[i-1];
          end
          st_key[0] = w.key;
          st_val[0] = w.value;
          st_vld[0] = 1'b1;
          // drops the evicted entry and anything left over from a larger capacity
          for (int i = lim; i < SLOTS; i++) st_vld[i] = 1'b0;
        end
      end
      default: begin
        if (hit >= 0) begin
          for (int i = hit; i < SLOTS - 1; i++) begin
            st_key[i] = st_key[i+1];
            st_val[i] = st_val[i+1];
            st_vld[i] = st_vld[i+1];
          end
          st_key[SLOTS-1] = '0;
          st_val[SLOTS-1] = '0;
          st_vld[SLOTS-1] = 1'b0;
        end
      end
    endcase
    return r;
  endfunction

  // present one word, hold it until taken, then record the answer it must give
  task automatic send_word(input lkv_in_t w, input bit typed, input lkv_out_t want);
    lkv_out_t pred;
    @(negedge clk);
    start <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (busy);
    pred = lru_apply(w);
    expected_words.push_back(typed ? want : pred);
  endtask

  // drop start and hold the request side quiet; n sets the gap, zero skips it
  task automatic idle_for(input int n);
    if (n > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // capacity write, only once every outstanding answer is back
  task automatic write_cap(input logic [CAP_W-1:0] c);
    @(negedge clk);
    start <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= c;
    do @(posedge clk); while (!cfg_ready);
    cap_reg = c;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly back to back, sometimes short pauses, now and then a long one
  function automatic int next_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 65) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // answer checker: one word per strobe, in request order
  always @(posedge clk) begin
    lkv_out_t want;
    if (rst_n && out_valid) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected result word found=%0b read_value=%h",
                 $time, out_data.found, out_data.read_value);
        err_cnt++;
      end else begin
        want = expected_words.pop_front();
        if (out_data.found !== want.found) begin
          $display("%0t: found mismatch, expected %0b, actual %0b",
                   $time, want.found, out_data.found);
          err_cnt++;
        end
        if (out_data.read_value !== want.read_value) begin
          $display("%0t: read_value mismatch, expected %h, actual %h",
                   $time, want.read_value, out_data.read_value);
          err_cnt++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    lkv_in_t w;
    lkv_out_t want;
    logic [31:0] key_pool [32];
    int pool_n;
    int r;
    cap_reg = CAP_RESET;
    for (int i = 0; i < SLOTS; i++) begin
      st_key[i] = '0;
      st_val[i] = '0;
      st_vld[i] = 1'b0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int n = 0; n < N_ROWS; n++) begin
      if (DIR_TAB[n].kind == ROW_CFG) begin
        write_cap(DIR_TAB[n].cap);
      end else begin
        w.func = DIR_TAB[n].func;
        w.key = DIR_TAB[n].key;
        w.value = DIR_TAB[n].value;
        want.found = DIR_TAB[n].found;
        want.read_value = DIR_TAB[n].rv;
        send_word(w, DIR_TAB[n].typed, want);
        idle_for(next_gap());
      end
    end

    // random phases, each with its own capacity and key pool
    want = '0;
    for (int p = 0; p < N_PHASES; p++) begin
      write_cap(PHASE_CAP[p]);
      burst_mode = ($urandom_range(0, 3) == 0);
      // pool a bit larger than the capacity keeps hits and evictions frequent
      pool_n = ((PHASE_CAP[p] == 0) ? 1 : ((PHASE_CAP[p] > SLOTS) ? SLOTS : PHASE_CAP[p]))
               + $urandom_range(1, 6);
      for (int i = 0; i < pool_n; i++) begin
        case ($urandom_range(0, 19))
          0: key_pool[i] = 32'h0000_0000;
          1: key_pool[i] = 32'hFFFF_FFFF;
          2: key_pool[i] = 32'h8000_0000;
          3: key_pool[i] = 32'h7FFF_FFFF;
          default: key_pool[i] = $urandom;
        endcase
      end
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        r = $urandom_range(0, 99);
        if (r < 40) w.func = FN_INSERT;
        else if (r < 72) w.func = FN_LOOKUP;
        else if (r < 94) w.func = FN_ERASE;
        else w.func = FN_NOP;
        w.key = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, pool_n - 1)];
        w.value = $urandom;
        send_word(w, 1'b0, want);
        idle_for(next_gap());
      end
    end

    // drain and let the pipeline settle
    @(negedge clk);
    start <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
